// ----- rtl/assert_macros.svh -----
// Assertion macros for the point-to-segment distance block.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psd assertion failed");
`define PSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psd assertion failed");
`else
`define PSD_ASSERT_IMPL(label, ante, cons)
`define PSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/psd_pkg.sv -----
// Shared widths, result kind codes and queue types for point_segment_distance.
// Used by every module of the block.
package psd_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DW         = COORD_BITS + 1;          // coordinate difference
  localparam int PW         = 2 * DW;                  // product of two differences
  localparam int NUMW       = 4 * DW + 2 * FRAC_BITS;  // divider numerator
  localparam int QW         = 2 * DW - 1 + 2 * FRAC_BITS; // quotient / radicand
  localparam int SQW        = (QW + 1) / 2;            // square root
  localparam int DIST_BITS  = 25;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_DEGEN = 2'd0,
    KIND_A     = 2'd1,
    KIND_B     = 2'd2,
    KIND_PERP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [PW-1:0]  sumsq;   // squared endpoint distance
    logic [PW-1:0]  cmag;    // |cross|
    logic [PW-1:0]  len2;    // squared segment length
  } qent_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QAW:0]   count;
  } qstat_t;
endpackage

// ----- rtl/psd_front.sv -----
// Front end: takes input beats, forms differences and products, classifies
// the nearest part of the segment and pushes one queue entry. Uses psd_pkg.
module psd_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_end_y,
  output logic                                 push,
  output psd_pkg::qent_t                       push_data,
  input  psd_pkg::qstat_t                      q_stat
);
  import psd_pkg::*;

  logic en;
  logic f1_v_r, f2_v_r;
  logic signed [DW-1:0] v1x_r, v1y_r, v2x_r, v2y_r, v3x_r, v3y_r;
  logic signed [PW-1:0] d1a_r, d1b_r, d2a_r, d2b_r, ca_r, cb_r;
  logic signed [PW-1:0] s2x_r, s2y_r, s3x_r, s3y_r, l1x_r, l1y_r;
  logic degen_r;
  logic signed [PW:0] dot1, dot2, crs, crsn;
  kind_t kind;

  assign en       = !f2_v_r || !q_stat.full;
  assign in_stall = !en;
  assign push     = f2_v_r && !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1x_r <= {in_end_x[COORD_BITS-1], in_end_x} - {in_start_x[COORD_BITS-1], in_start_x};
      v1y_r <= {in_end_y[COORD_BITS-1], in_end_y} - {in_start_y[COORD_BITS-1], in_start_y};
      v2x_r <= {in_point_x[COORD_BITS-1], in_point_x} - {in_start_x[COORD_BITS-1], in_start_x};
      v2y_r <= {in_point_y[COORD_BITS-1], in_point_y} - {in_start_y[COORD_BITS-1], in_start_y};
      v3x_r <= {in_point_x[COORD_BITS-1], in_point_x} - {in_end_x[COORD_BITS-1], in_end_x};
      v3y_r <= {in_point_y[COORD_BITS-1], in_point_y} - {in_end_y[COORD_BITS-1], in_end_y};
      d1a_r <= v1x_r * v2x_r;
      d1b_r <= v1y_r * v2y_r;
      d2a_r <= v1x_r * v3x_r;
      d2b_r <= v1y_r * v3y_r;
      ca_r  <= v1x_r * v2y_r;
      cb_r  <= v2x_r * v1y_r;
      s2x_r <= v2x_r * v2x_r;
      s2y_r <= v2y_r * v2y_r;
      s3x_r <= v3x_r * v3x_r;
      s3y_r <= v3y_r * v3y_r;
      l1x_r <= v1x_r * v1x_r;
      l1y_r <= v1y_r * v1y_r;
      degen_r <= (v1x_r == '0) && (v1y_r == '0);
    end
  end

  always_comb begin
    dot1 = {d1a_r[PW-1], d1a_r} + {d1b_r[PW-1], d1b_r};
    dot2 = {d2a_r[PW-1], d2a_r} + {d2b_r[PW-1], d2b_r};
    crs  = {ca_r[PW-1], ca_r} - {cb_r[PW-1], cb_r};
    crsn = {cb_r[PW-1], cb_r} - {ca_r[PW-1], ca_r};
    if (degen_r)                      kind = KIND_DEGEN;
    else if (dot1[PW])                kind = KIND_A;
    else if (dot2 != '0 && !dot2[PW]) kind = KIND_B;
    else                              kind = KIND_PERP;
    push_data.kind  = kind;
    push_data.sumsq = (kind == KIND_B) ? PW'($unsigned(s3x_r) + $unsigned(s3y_r))
                                       : PW'($unsigned(s2x_r) + $unsigned(s2y_r));
    push_data.cmag  = crs[PW] ? crsn[PW-1:0] : crs[PW-1:0];
    push_data.len2  = PW'($unsigned(l1x_r) + $unsigned(l1y_r));
  end
endmodule

// ----- rtl/psd_queue.sv -----
// Short FIFO between front end and back end; one entry per classified beat.
// Uses psd_pkg.
module psd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psd_pkg::qent_t    push_data,
  input  logic              pop,
  output psd_pkg::qent_t    pop_data,
  output psd_pkg::qstat_t   q_stat
);
  import psd_pkg::*;

  qent_t          ent_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign pop_data     = ent_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end
endmodule

// ----- rtl/psd_back.sv -----
// Back end: squares |cross|, pipelined restoring divider (one quotient bit per
// stage), pipelined digit-by-digit square root, output register. Uses psd_pkg.
module psd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  psd_pkg::qstat_t                  q_stat,
  input  psd_pkg::qent_t                   pop_data,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [psd_pkg::DIST_BITS-1:0]    out_distance,
  output logic [1:0]                       out_nearest_kind
);
  import psd_pkg::*;

  logic be;
  // square of |cross| split in halves
  logic          b1_v_r;
  kind_t         b1_k_r;
  logic [PW-1:0] b1_sumsq_r, b1_len2_r, hh_r, hl_r, ll_r;
  logic [4*DW-1:0] c2;
  logic [NUMW-1:0] num;
  // divider stages
  logic          dv_r  [QW+1];
  kind_t         dk_r  [QW+1];
  logic [PW-1:0] drem_r[QW+1];
  logic [QW-1:0] dlow_r[QW+1];
  logic [PW-1:0] dden_r[QW+1];
  // root stages
  logic            sv_r   [SQW+1];
  kind_t           sk_r   [SQW+1];
  logic [2*SQW-1:0] srad_r[SQW+1];
  logic [SQW-1:0]  sroot_r[SQW+1];
  logic [SQW+1:0]  srem_r [SQW+1];
  logic                 out_v_r;
  logic [DIST_BITS-1:0] out_d_r;
  kind_t                out_k_r;

  assign be  = !out_v_r || !out_stall;
  assign pop = !q_stat.empty && be;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (be) begin
      b1_v_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b1_k_r     <= pop_data.kind;
      b1_sumsq_r <= pop_data.sumsq;
      b1_len2_r  <= pop_data.len2;
      hh_r <= pop_data.cmag[PW-1:DW] * pop_data.cmag[PW-1:DW];
      hl_r <= pop_data.cmag[PW-1:DW] * pop_data.cmag[DW-1:0];
      ll_r <= pop_data.cmag[DW-1:0]  * pop_data.cmag[DW-1:0];
    end
  end

  always_comb begin
    c2 = {hh_r, {PW{1'b0}}} + {{(DW-1){1'b0}}, hl_r, {(DW+1){1'b0}}}
       + {{PW{1'b0}}, ll_r};
    if (b1_k_r == KIND_PERP) num = NUMW'(c2) << (2 * FRAC_BITS);
    else                     num = NUMW'(b1_sumsq_r) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (be) begin
      dv_r[0] <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      dk_r[0]   <= b1_k_r;
      drem_r[0] <= num[QW +: PW];
      dlow_r[0] <= num[QW-1:0];
      dden_r[0] <= (b1_k_r == KIND_PERP) ? b1_len2_r : PW'(1);
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [PW:0] trial, diff;
    logic        ge;
    always_comb begin
      trial = {drem_r[i], dlow_r[i][QW-1]};
      diff  = trial - {1'b0, dden_r[i]};
      ge    = (trial >= {1'b0, dden_r[i]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (be) begin
        dv_r[i+1] <= dv_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (be) begin
        dk_r[i+1]   <= dk_r[i];
        drem_r[i+1] <= ge ? diff[PW-1:0] : trial[PW-1:0];
        dlow_r[i+1] <= {dlow_r[i][QW-2:0], ge};
        dden_r[i+1] <= dden_r[i];
      end
    end
  end

  always_comb begin
    sv_r[0]    = dv_r[QW];
    sk_r[0]    = dk_r[QW];
    srad_r[0]  = (2*SQW)'(dlow_r[QW]);
    sroot_r[0] = '0;
    srem_r[0]  = '0;
  end

  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    logic [SQW+3:0] cur, trial;
    logic           ge;
    always_comb begin
      cur   = {srem_r[j], srad_r[j][2*SQW-1 -: 2]};
      trial = (SQW+4)'({sroot_r[j], 2'b01});
      ge    = (cur >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else if (be) begin
        sv_r[j+1] <= sv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (be) begin
        sk_r[j+1]    <= sk_r[j];
        srad_r[j+1]  <= srad_r[j] << 2;
        sroot_r[j+1] <= {sroot_r[j][SQW-2:0], ge};
        srem_r[j+1]  <= ge ? (SQW+2)'(cur - trial) : (SQW+2)'(cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (be) begin
      out_v_r <= sv_r[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_d_r <= DIST_BITS'(sroot_r[SQW]);
      out_k_r <= sk_r[SQW];
    end
  end

  assign out_valid        = out_v_r;
  assign out_distance     = out_d_r;
  assign out_nearest_kind = out_k_r;
endmodule

// ----- rtl/point_segment_distance.sv -----
// Channel  | ports                                   | direction
// in       | in_valid, in_stall, in_point_*, in_start_*, in_end_* | input beats
// out      | out_valid, out_stall, out_distance, out_nearest_kind | result beats
// One beat in and one out per cycle when neither side stalls.
// Path: front stages f1 and f2, the queue, the b1 squaring stage, the divider input
// register, divider and root stages (which set the depth) and the output register.
// Reset (rst_n low, synchronous) empties all stages and the 4-entry queue.
// out_stall freezes the back end only; the front keeps filling the queue
// and raises in_stall when it is full with a beat waiting.
// Top level of the block; depends on psd_pkg, psd_front, psd_queue, psd_back and assert_macros.svh.
`include "assert_macros.svh"
module point_segment_distance (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [psd_pkg::COORD_BITS-1:0] in_end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [psd_pkg::DIST_BITS-1:0]        out_distance,
  output logic [1:0]                           out_nearest_kind
);
  import psd_pkg::*;

  logic   push, pop;
  qent_t  push_data, pop_data;
  qstat_t q_stat;

  psd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_point_x, .in_point_y, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .push, .push_data, .q_stat
  );

  psd_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .q_stat
  );

  psd_back u_back (
    .clk, .rst_n, .q_stat, .pop_data, .pop,
    .out_valid, .out_stall, .out_distance, .out_nearest_kind
  );

  `PSD_ASSERT_IMPL(a_qcount_range, 1'b1, q_stat.count <= (QAW+1)'(QDEPTH))
  `PSD_ASSERT_IMPL(a_stall_cause, in_stall, q_stat.full)
  `PSD_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
endmodule
